// ----- rtl/kei_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kei_pkg: shared types and constants
// Key table sizing, status and probe mode codes, the key record, the probe
// that walks the key cells and the job handed to the interpolation unit.
// ----------------------------------------------------------------------------
package kei_pkg;

	localparam int MAX_KEYS  = 8;
	localparam int KEY_IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int KEY_CNT_W = $clog2(MAX_KEYS + 1);

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_EVAL   = 1'b1;

	localparam logic [2:0] STATUS_OK      = 3'd0;
	localparam logic [2:0] STATUS_FEW     = 3'd1;
	localparam logic [2:0] STATUS_OUTSIDE = 3'd2;
	localparam logic [2:0] STATUS_STORED  = 3'd3;
	localparam logic [2:0] STATUS_FULL    = 3'd4;

	localparam logic [1:0] MODE_SEG   = 2'd0;
	localparam logic [1:0] MODE_FIRST = 2'd1;
	localparam logic [1:0] MODE_LAST  = 2'd2;

	typedef struct packed {
		logic [16:0]        ktime;
		logic signed [15:0] kval;
		logic [16:0]        kenv;
	} key_t;

	typedef struct packed {
		logic        active;
		logic [1:0]  mode;
		logic        found;
		logic [16:0] qtime;
		key_t        prev;
		key_t        seg0;
		key_t        seg1;
	} probe_t;

	typedef struct packed {
		logic               use_div;
		logic [16:0]        qtime;
		logic [16:0]        t0;
		logic [16:0]        t1;
		logic signed [15:0] v0;
		logic signed [15:0] v1;
		logic [16:0]        e0;
		logic [16:0]        e1;
		logic [15:0]        dev;
	} math_job_t;

endpackage
`default_nettype wire

// ----- rtl/kei_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kei_in_if: request channel
// Valid/ready channel carrying insert and evaluate requests.
// ----------------------------------------------------------------------------
interface kei_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [16:0]        key_time;
	logic signed [15:0] key_value;
	logic [16:0]        key_envelope;
	logic [16:0]        query_time;
	logic [15:0]        deviation;

	modport source (output valid, kind, key_time, key_value, key_envelope, query_time,
		deviation, input ready);
	modport sink (input valid, kind, key_time, key_value, key_envelope, query_time,
		deviation, output ready);
endinterface
`default_nettype wire

// ----- rtl/kei_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kei_out_if: result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface kei_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] result_value;
	logic [2:0]         status;

	modport source (output valid, result_value, status, input ready);
	modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/kei_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kei_cell: one key cell
// Stores one keyframe and registers the probe passing through it, marking
// the segment that ends at this key or the key picked for an end point.
// ----------------------------------------------------------------------------
module kei_cell (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [kei_pkg::KEY_IDX_W-1:0]  idx,
	input  wire  [kei_pkg::KEY_CNT_W-1:0]  count,
	input  wire                            wr,
	input  kei_pkg::key_t                  wkey,
	input  kei_pkg::probe_t                pin,
	output kei_pkg::probe_t                pout
);
	import kei_pkg::*;

	key_t                 key_q;
	probe_t               probe_q;
	probe_t               probe_d;
	logic [KEY_CNT_W-1:0] idx_c;

	assign idx_c = KEY_CNT_W'(idx);

	always_ff @(posedge clk) begin
		if (wr && (count == idx_c)) begin
			key_q <= wkey;
		end
	end

	always_comb begin
		probe_d      = pin;
		probe_d.prev = key_q;
		unique case (pin.mode)
			MODE_FIRST: begin
				if (idx_c == '0) begin
					probe_d.found = 1'b1;
					probe_d.seg0  = key_q;
				end
			end
			MODE_LAST: begin
				if (idx_c == count - KEY_CNT_W'(1)) begin
					probe_d.found = 1'b1;
					probe_d.seg0  = key_q;
				end
			end
			default: begin
				if ((idx_c != '0) && (idx_c < count) && !pin.found &&
					(pin.qtime >= pin.prev.ktime) && (pin.qtime < key_q.ktime)) begin
					probe_d.found = 1'b1;
					probe_d.seg0  = pin.prev;
					probe_d.seg1  = key_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

	assign pout = probe_q;

endmodule
`default_nettype wire

// ----- rtl/kei_math.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kei_math: interpolation unit
// Radix-2 divider for the segment fraction, then a shared multiplier for
// envelope lerp, value lerp, envelope times deviation and the final scale.
// ----------------------------------------------------------------------------
module kei_math (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  kei_pkg::math_job_t  job,
	output logic                done,
	output logic signed [15:0]  result_value
);
	import kei_pkg::*;

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_DIV  = 3'd1;
	localparam logic [2:0] M_ENV  = 3'd2;
	localparam logic [2:0] M_VAL  = 3'd3;
	localparam logic [2:0] M_FAC  = 3'd4;
	localparam logic [2:0] M_RES  = 3'd5;
	localparam logic [2:0] M_SAT  = 3'd6;

	logic [2:0]         mst_q;
	math_job_t          job_q;
	logic [16:0]        rem_q;
	logic [15:0]        alpha_q;
	logic [3:0]         step_q;
	logic signed [37:0] prod_q;
	logic signed [18:0] env_q;
	logic signed [18:0] val_q;

	logic [16:0]        den;
	logic [17:0]        r2;
	logic [17:0]        r2_sub;
	logic               ge;
	logic signed [18:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [37:0] mul_p;
	logic signed [21:0] tz;
	logic signed [18:0] env_d;
	logic signed [18:0] val_d;

	function automatic logic signed [21:0] trunc_q16(input logic signed [37:0] p);
		logic signed [37:0] adj;
		adj = p + (p[37] ? 38'sd65535 : 38'sd0);
		return adj[37:16];
	endfunction

	assign den    = job_q.t1 - job_q.t0;
	assign r2     = {rem_q, 1'b0};
	assign r2_sub = r2 - {1'b0, den};
	assign ge     = (r2 >= {1'b0, den});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (mst_q)
			M_ENV: begin
				mul_a = $signed({2'b00, job_q.e1}) - $signed({2'b00, job_q.e0});
				mul_b = $signed({3'b000, alpha_q});
			end
			M_VAL: begin
				mul_a = $signed({{3{job_q.v1[15]}}, job_q.v1}) -
					$signed({{3{job_q.v0[15]}}, job_q.v0});
				mul_b = $signed({3'b000, alpha_q});
			end
			M_FAC: begin
				mul_a = env_q[18] ? 19'sd0 : env_q;
				mul_b = $signed({3'b000, job_q.dev});
			end
			M_RES: begin
				mul_a = val_q;
				mul_b = $signed({2'b00, prod_q[32:16]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign tz    = trunc_q16(prod_q);
	assign env_d = $signed({2'b00, job_q.e0}) + tz[18:0];
	assign val_d = $signed({{3{job_q.v0[15]}}, job_q.v0}) + tz[18:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q <= M_IDLE;
		end else begin
			unique case (mst_q)
				M_IDLE: if (start) mst_q <= job.use_div ? M_DIV : M_ENV;
				M_DIV:  if (step_q == '0) mst_q <= M_ENV;
				M_ENV:  mst_q <= M_VAL;
				M_VAL:  mst_q <= M_FAC;
				M_FAC:  mst_q <= M_RES;
				M_RES:  mst_q <= M_SAT;
				default: mst_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (mst_q)
			M_IDLE: begin
				if (start) begin
					job_q   <= job;
					rem_q   <= job.qtime - job.t0;
					alpha_q <= '0;
					step_q  <= 4'd15;
				end
			end
			M_DIV: begin
				rem_q   <= ge ? r2_sub[16:0] : r2[16:0];
				alpha_q <= {alpha_q[14:0], ge};
				step_q  <= step_q - 4'd1;
			end
			M_ENV: begin
				prod_q <= mul_p;
			end
			M_VAL: begin
				env_q  <= env_d;
				prod_q <= mul_p;
			end
			M_FAC: begin
				val_q  <= val_d;
				prod_q <= mul_p;
			end
			M_RES: begin
				prod_q <= mul_p;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		done = (mst_q == M_SAT);
		if (tz > 22'sd32767) begin
			result_value = 16'sh7FFF;
		end else if (tz < -22'sd32768) begin
			result_value = 16'sh8000;
		end else begin
			result_value = tz[15:0];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/keyframe_envelope_interpolator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_envelope_interpolator: keyframe table with envelope interpolation
// Stores up to MAX_KEYS keyframes in a row of key cells and evaluates the
// piecewise linear curve, scaled by envelope and deviation, on request.
//
// Channels: item (sink) takes insert and evaluate requests, result (source)
// returns one result per request. Both are valid/ready; a transfer happens
// when valid and ready are high at a rising edge.
// An insert returns its status through the done state and the output
// register. An evaluate sends a probe down the key cells, one cell per cycle,
// then runs a radix-2 divide for the segment fraction and four multiplies
// on one shared multiplier. End points (time 0 and 1.0) skip the divide.
// One request is in flight at a time; item.ready is high while the block
// is idle. The result sits in an output register, so the next request is
// taken while that result waits; a stalled receiver holds the result and,
// once a second one is finished, holds off further requests.
// Reset empties the table (key count zero), clears result valid and returns to idle.
// ----------------------------------------------------------------------------
module keyframe_envelope_interpolator (
	input wire         clk,
	input wire         arst_n,
	kei_in_if.sink     item,
	kei_out_if.source  result
);
	import kei_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_MATH = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]           state_q;
	logic [KEY_CNT_W-1:0] count_q;
	logic [15:0]          dev_q;
	probe_t               launch_q;
	logic signed [15:0]   pend_val_q;
	logic [2:0]           pend_status_q;
	logic                 out_valid_q;
	logic signed [15:0]   out_val_q;
	logic [2:0]           out_status_q;

	probe_t               chain [MAX_KEYS+1];
	logic [MAX_KEYS:0]    probe_act;
	probe_t               exit_p;
	key_t                 wkey;
	probe_t               launch_d;
	logic                 accept;
	logic                 ins_wr;
	logic                 full;
	logic                 no_seg;
	logic                 math_start;
	math_job_t            math_job;
	logic                 math_done;
	logic signed [15:0]   math_val;
	logic                 out_load;

	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;
	assign full       = (count_q >= KEY_CNT_W'(MAX_KEYS));
	assign ins_wr     = accept && (item.kind == KIND_INSERT) && !full;

	assign wkey.ktime = item.key_time;
	assign wkey.kval  = item.key_value;
	assign wkey.kenv  = item.key_envelope;

	always_comb begin
		launch_d        = '0;
		launch_d.active = accept && (item.kind == KIND_EVAL) && (count_q >= KEY_CNT_W'(2));
		launch_d.qtime  = item.query_time;
		if (item.query_time == '0) begin
			launch_d.mode = MODE_FIRST;
		end else if (item.query_time == ONE_Q16) begin
			launch_d.mode = MODE_LAST;
		end else begin
			launch_d.mode = MODE_SEG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
		end else begin
			launch_q <= launch_d;
		end
	end

	assign chain[0] = launch_q;

	for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
		kei_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (KEY_IDX_W'(i)),
			.count  (count_q),
			.wr     (ins_wr),
			.wkey   (wkey),
			.pin    (chain[i]),
			.pout   (chain[i+1])
		);
	end

	for (genvar i = 0; i <= MAX_KEYS; i++) begin : g_act
		assign probe_act[i] = chain[i].active;
	end

	assign exit_p     = chain[MAX_KEYS];
	assign no_seg     = (exit_p.mode == MODE_SEG) && !exit_p.found;
	assign math_start = (state_q == S_SCAN) && exit_p.active && !no_seg;

	assign math_job.use_div = (exit_p.mode == MODE_SEG);
	assign math_job.qtime   = exit_p.qtime;
	assign math_job.t0      = exit_p.seg0.ktime;
	assign math_job.t1      = exit_p.seg1.ktime;
	assign math_job.v0      = exit_p.seg0.kval;
	assign math_job.v1      = exit_p.seg1.kval;
	assign math_job.e0      = exit_p.seg0.kenv;
	assign math_job.e1      = exit_p.seg1.kenv;
	assign math_job.dev     = dev_q;

	kei_math u_math (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (math_start),
		.job          (math_job),
		.done         (math_done),
		.result_value (math_val)
	);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.kind == KIND_INSERT) begin
							state_q <= S_DONE;
							if (!full) count_q <= count_q + KEY_CNT_W'(1);
						end else if (count_q < KEY_CNT_W'(2)) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (exit_p.active) state_q <= no_seg ? S_DONE : S_MATH;
				end
				S_MATH: begin
					if (math_done) state_q <= S_DONE;
				end
				default: begin
					if (out_load) state_q <= S_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dev_q      <= item.deviation;
			pend_val_q <= '0;
			if (item.kind == KIND_INSERT) begin
				pend_status_q <= full ? STATUS_FULL : STATUS_STORED;
			end else begin
				pend_status_q <= STATUS_FEW;
			end
		end else if ((state_q == S_SCAN) && exit_p.active && no_seg) begin
			pend_val_q    <= '0;
			pend_status_q <= STATUS_OUTSIDE;
		end else if ((state_q == S_MATH) && math_done) begin
			pend_val_q    <= math_val;
			pend_status_q <= STATUS_OK;
		end
		if (out_load) begin
			out_val_q    <= pend_val_q;
			out_status_q <= pend_status_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_value = out_val_q;
	assign result.status       = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= KEY_CNT_W'(MAX_KEYS))
		else $error("key count above table size");

	a_one_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(probe_act) <= 1)
		else $error("more than one probe in the key cells");

	a_exit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		exit_p.active |-> state_q == S_SCAN)
		else $error("probe left the cells outside the scan");

	a_done_in_math: assert property (@(posedge clk) disable iff (!arst_n)
		math_done |-> state_q == S_MATH)
		else $error("interpolation finished with no evaluate pending");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("request accepted without leaving idle");

endmodule
`default_nettype wire
